>>> design/assert_macros.svh
// assertion macros for the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHK_IMPLIES(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define CHK_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/jam_pkg.sv
// shared types and constants for the jacobian adjugate block
package jam_pkg;

  localparam int IN_W   = 24;
  localparam int DET_W  = 48;
  localparam int ADJ_W  = 40;
  localparam int DIM_W  = 2;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int STEP_W = 5;
  localparam int NUM_ADJ = 9;

  // product schedule: two products per adjugate term, then two per determinant term
  localparam logic [STEP_W-1:0] CROSS_STEPS   = 5'd18;
  localparam logic [STEP_W-1:0] STEP_LAST_3D  = 5'd23;
  localparam logic [STEP_W-1:0] STEP_FIRST_2D = 5'd16;
  localparam logic [STEP_W-1:0] STEP_LAST_2D  = 5'd17;

  localparam logic [DIM_W-1:0] DIM_RESET  = 2'd3;
  localparam logic [DIM_W-1:0] DIM_PLANAR = 2'd2;
  localparam logic             REG_DIM    = 1'b0;

  localparam logic signed [DET_W-1:0] DET_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [DET_W-1:0] DET_MIN = 48'sh8000_0000_0000;
  localparam logic signed [ADJ_W-1:0] ADJ_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [ADJ_W-1:0] ADJ_MIN = 40'sh80_0000_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DRAIN,
    ST_DONE
  } jam_state_t;

  typedef struct packed {
    logic              capture;
    logic              mul_en;
    logic [STEP_W-1:0] step;
    logic              planar;
    logic              load;
  } jam_cmd_t;

endpackage

>>> design/jam_ctrl.sv
// sequencer that steps the shared multiplier through one point
module jam_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              pt_valid,
  output logic              pt_stall,
  output logic              res_valid,
  input  logic              res_stall,
  input  logic              planar,
  output jam_pkg::jam_cmd_t cmd
);

  jam_pkg::jam_state_t state, state_next;
  logic [jam_pkg::STEP_W-1:0] step, step_next;
  logic planar_mode, planar_mode_next;
  logic res_valid_next;
  logic [jam_pkg::STEP_W-1:0] last_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= jam_pkg::ST_IDLE;
      step        <= '0;
      planar_mode <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      step        <= step_next;
      planar_mode <= planar_mode_next;
      res_valid   <= res_valid_next;
    end
  end

  assign last_step = planar_mode ? jam_pkg::STEP_LAST_2D : jam_pkg::STEP_LAST_3D;
  assign pt_stall  = (state != jam_pkg::ST_IDLE);

  always_comb begin
    state_next       = state;
    step_next        = step;
    planar_mode_next = planar_mode;
    cmd              = '0;
    cmd.step         = step;
    cmd.planar       = planar_mode;
    case (state)
      jam_pkg::ST_IDLE: begin
        if (pt_valid) begin
          cmd.capture      = 1'b1;
          planar_mode_next = planar;
          step_next        = planar ? jam_pkg::STEP_FIRST_2D : '0;
          state_next       = jam_pkg::ST_MUL;
        end
      end
      jam_pkg::ST_MUL: begin
        cmd.mul_en = 1'b1;
        if (step == last_step) begin
          state_next = jam_pkg::ST_DRAIN;
        end else begin
          step_next = step + 1'b1;
        end
      end
      jam_pkg::ST_DRAIN: begin
        state_next = jam_pkg::ST_DONE;
      end
      jam_pkg::ST_DONE: begin
        if (!res_valid || !res_stall) begin
          cmd.load   = 1'b1;
          state_next = jam_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = jam_pkg::ST_IDLE;
      end
    endcase
    res_valid_next = cmd.load | (res_valid & res_stall);
  end

endmodule

>>> design/jam_dpath.sv
// operand registers, shared multiplier, accumulators, min/max and result registers
module jam_dpath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  jam_pkg::jam_cmd_t                   cmd,
  input  logic signed [jam_pkg::IN_W-1:0]     dx_dr,
  input  logic signed [jam_pkg::IN_W-1:0]     dy_dr,
  input  logic signed [jam_pkg::IN_W-1:0]     dz_dr,
  input  logic signed [jam_pkg::IN_W-1:0]     dx_ds,
  input  logic signed [jam_pkg::IN_W-1:0]     dy_ds,
  input  logic signed [jam_pkg::IN_W-1:0]     dz_ds,
  input  logic signed [jam_pkg::IN_W-1:0]     dx_dt,
  input  logic signed [jam_pkg::IN_W-1:0]     dy_dt,
  input  logic signed [jam_pkg::IN_W-1:0]     dz_dt,
  input  logic                                first_point,
  input  logic                                is_padding,
  output logic signed [jam_pkg::DET_W-1:0]    determinant,
  output logic signed [jam_pkg::ADJ_W-1:0]    adj_r_x,
  output logic signed [jam_pkg::ADJ_W-1:0]    adj_s_x,
  output logic signed [jam_pkg::ADJ_W-1:0]    adj_t_x,
  output logic signed [jam_pkg::ADJ_W-1:0]    adj_r_y,
  output logic signed [jam_pkg::ADJ_W-1:0]    adj_s_y,
  output logic signed [jam_pkg::ADJ_W-1:0]    adj_t_y,
  output logic signed [jam_pkg::ADJ_W-1:0]    adj_r_z,
  output logic signed [jam_pkg::ADJ_W-1:0]    adj_s_z,
  output logic signed [jam_pkg::ADJ_W-1:0]    adj_t_z,
  output logic signed [jam_pkg::DET_W-1:0]    running_min,
  output logic signed [jam_pkg::DET_W-1:0]    running_max
);

  localparam int IW      = jam_pkg::IN_W;
  localparam int OP_W    = IW + 1;
  localparam int MUL_W   = 2 * OP_W;
  localparam int DIFF_W  = MUL_W + 1;
  localparam int CROSS_W = 2 * IW + 1;
  localparam int AW      = CROSS_W - FRAC_BITS;
  localparam int PW      = IW + AW;
  localparam int DW      = PW - FRAC_BITS + 2;
  localparam int DAW     = (DW > jam_pkg::DET_W) ? DW : jam_pkg::DET_W + 1;
  localparam int AAW     = (AW > jam_pkg::ADJ_W) ? AW : jam_pkg::ADJ_W + 1;

  logic signed [IW-1:0] xr, yr, zr, xs, ys, zs, xt, yt, zt;
  logic pt_first, pt_pad;

  logic signed [IW-1:0]    op_a;
  logic signed [OP_W-1:0]  op_b;
  logic signed [MUL_W-1:0] p;
  logic signed [MUL_W-1:0] acc;
  logic                    acc_en;
  logic [jam_pkg::STEP_W-1:0] step_d;
  logic                    planar_d;

  logic signed [AW-1:0]  adj [jam_pkg::NUM_ADJ];
  logic signed [DAW-1:0] det_acc;

  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [PW-1:0]     xprod;
  logic signed [PW-1:0]     xprod_q;
  logic signed [DAW-1:0]    term;

  logic signed [jam_pkg::DET_W-1:0] det_sat;
  logic signed [jam_pkg::ADJ_W-1:0] adj_res [jam_pkg::NUM_ADJ];
  logic signed [AAW-1:0]            adj_wide;
  logic signed [jam_pkg::DET_W-1:0] min_so_far, max_so_far;
  logic signed [jam_pkg::DET_W-1:0] min_next, max_next;

  // point capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      xr       <= dx_dr;
      yr       <= dy_dr;
      zr       <= dz_dr;
      xs       <= dx_ds;
      ys       <= dy_ds;
      zs       <= dz_ds;
      xt       <= dx_dt;
      yt       <= dy_dt;
      zt       <= dz_dt;
      pt_first <= first_point;
      pt_pad   <= is_padding;
    end
  end

  // operand schedule: cross products of the adjugate, then split det products
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.step)
      5'd0:  begin op_a = ys; op_b = OP_W'(zt); end
      5'd1:  begin op_a = zs; op_b = OP_W'(yt); end
      5'd2:  begin op_a = zr; op_b = OP_W'(yt); end
      5'd3:  begin op_a = yr; op_b = OP_W'(zt); end
      5'd4:  begin op_a = yr; op_b = OP_W'(zs); end
      5'd5:  begin op_a = zr; op_b = OP_W'(ys); end
      5'd6:  begin op_a = zs; op_b = OP_W'(xt); end
      5'd7:  begin op_a = xs; op_b = OP_W'(zt); end
      5'd8:  begin op_a = xr; op_b = OP_W'(zt); end
      5'd9:  begin op_a = zr; op_b = OP_W'(xt); end
      5'd10: begin op_a = zr; op_b = OP_W'(xs); end
      5'd11: begin op_a = xr; op_b = OP_W'(zs); end
      5'd12: begin op_a = xs; op_b = OP_W'(yt); end
      5'd13: begin op_a = ys; op_b = OP_W'(xt); end
      5'd14: begin op_a = yr; op_b = OP_W'(xt); end
      5'd15: begin op_a = xr; op_b = OP_W'(yt); end
      5'd16: begin op_a = xr; op_b = OP_W'(ys); end
      5'd17: begin op_a = yr; op_b = OP_W'(xs); end
      5'd18: begin op_a = xr; op_b = OP_W'($signed(adj[0][AW-1:IW])); end
      5'd19: begin op_a = xr; op_b = OP_W'({1'b0, adj[0][IW-1:0]}); end
      5'd20: begin op_a = xs; op_b = OP_W'($signed(adj[1][AW-1:IW])); end
      5'd21: begin op_a = xs; op_b = OP_W'({1'b0, adj[1][IW-1:0]}); end
      5'd22: begin op_a = xt; op_b = OP_W'($signed(adj[2][AW-1:IW])); end
      5'd23: begin op_a = xt; op_b = OP_W'({1'b0, adj[2][IW-1:0]}); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_en <= 1'b0;
    end else begin
      acc_en <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    step_d   <= cmd.step;
    planar_d <= cmd.planar;
    if (cmd.mul_en) begin
      p <= MUL_W'(op_a) * MUL_W'(op_b);
    end
  end

  // accumulate stage
  assign diff    = DIFF_W'(acc) - DIFF_W'(p);
  assign diff_q  = diff >>> FRAC_BITS;
  assign xprod   = (PW'(acc) <<< IW) + PW'(p);
  assign xprod_q = xprod >>> FRAC_BITS;
  assign term    = DAW'(xprod_q);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      det_acc <= '0;
    end else if (acc_en) begin
      if (!step_d[0]) begin
        acc <= p;
      end else if (step_d < jam_pkg::CROSS_STEPS) begin
        if (planar_d) begin
          det_acc <= DAW'(diff_q);
        end else begin
          adj[step_d[jam_pkg::STEP_W-1:1]] <= AW'(diff_q);
        end
      end else begin
        det_acc <= det_acc + term;
      end
    end
  end

  // saturation and result selection
  always_comb begin
    if (det_acc > DAW'(jam_pkg::DET_MAX)) begin
      det_sat = jam_pkg::DET_MAX;
    end else if (det_acc < DAW'(jam_pkg::DET_MIN)) begin
      det_sat = jam_pkg::DET_MIN;
    end else begin
      det_sat = jam_pkg::DET_W'(det_acc);
    end
  end

  always_comb begin
    adj_wide = '0;
    for (int k = 0; k < jam_pkg::NUM_ADJ; k++) begin
      adj_wide = AAW'(adj[k]);
      if (cmd.planar) begin
        adj_res[k] = '0;
      end else if (adj_wide > AAW'(jam_pkg::ADJ_MAX)) begin
        adj_res[k] = jam_pkg::ADJ_MAX;
      end else if (adj_wide < AAW'(jam_pkg::ADJ_MIN)) begin
        adj_res[k] = jam_pkg::ADJ_MIN;
      end else begin
        adj_res[k] = jam_pkg::ADJ_W'(adj_wide);
      end
    end
    // planar terms come straight from the inputs
    if (cmd.planar) begin
      adj_res[0] = jam_pkg::ADJ_W'(ys);
      adj_res[1] = -jam_pkg::ADJ_W'(yr);
      adj_res[3] = -jam_pkg::ADJ_W'(xs);
      adj_res[4] = jam_pkg::ADJ_W'(xr);
    end
  end

  always_comb begin
    min_next = min_so_far;
    max_next = max_so_far;
    if (!pt_pad) begin
      if (pt_first) begin
        min_next = det_sat;
        max_next = det_sat;
      end else begin
        if (det_sat < min_so_far) min_next = det_sat;
        if (det_sat > max_so_far) max_next = det_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_so_far <= '0;
      max_so_far <= '0;
    end else if (cmd.load) begin
      min_so_far <= min_next;
      max_so_far <= max_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      determinant <= det_sat;
      adj_r_x     <= adj_res[0];
      adj_s_x     <= adj_res[1];
      adj_t_x     <= adj_res[2];
      adj_r_y     <= adj_res[3];
      adj_s_y     <= adj_res[4];
      adj_t_y     <= adj_res[5];
      adj_r_z     <= adj_res[6];
      adj_s_z     <= adj_res[7];
      adj_t_z     <= adj_res[8];
      running_min <= min_next;
      running_max <= max_next;
    end
  end

endmodule

>>> design/jacobian_adjugate_minmax_top.sv
// top level: jacobian determinant, adjugate terms and running min/max of the determinant
// a new point is taken only once the result of the last one is loaded; the single
//   shared 24x25 multiplier forms the 24 (3-d) or 2 (planar) products in turn
// reset: synchronous active-high rst idles the sequencer, zeroes min/max, dimension to 3
`include "assert_macros.svh"

module jacobian_adjugate_minmax_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [jam_pkg::ADDR_W-1:0]            paddr,
  input  logic [jam_pkg::DATA_W-1:0]            pwdata,
  output logic [jam_pkg::DATA_W-1:0]            prdata,
  output logic                                  pready,
  // point channel
  input  logic                                  pt_valid,
  output logic                                  pt_stall,
  input  logic signed [jam_pkg::IN_W-1:0]       dx_dr,
  input  logic signed [jam_pkg::IN_W-1:0]       dy_dr,
  input  logic signed [jam_pkg::IN_W-1:0]       dz_dr,
  input  logic signed [jam_pkg::IN_W-1:0]       dx_ds,
  input  logic signed [jam_pkg::IN_W-1:0]       dy_ds,
  input  logic signed [jam_pkg::IN_W-1:0]       dz_ds,
  input  logic signed [jam_pkg::IN_W-1:0]       dx_dt,
  input  logic signed [jam_pkg::IN_W-1:0]       dy_dt,
  input  logic signed [jam_pkg::IN_W-1:0]       dz_dt,
  input  logic                                  first_point,
  input  logic                                  is_padding,
  // result channel
  output logic                                  res_valid,
  input  logic                                  res_stall,
  output logic signed [jam_pkg::DET_W-1:0]      determinant,
  output logic signed [jam_pkg::ADJ_W-1:0]      adj_r_x,
  output logic signed [jam_pkg::ADJ_W-1:0]      adj_s_x,
  output logic signed [jam_pkg::ADJ_W-1:0]      adj_t_x,
  output logic signed [jam_pkg::ADJ_W-1:0]      adj_r_y,
  output logic signed [jam_pkg::ADJ_W-1:0]      adj_s_y,
  output logic signed [jam_pkg::ADJ_W-1:0]      adj_t_y,
  output logic signed [jam_pkg::ADJ_W-1:0]      adj_r_z,
  output logic signed [jam_pkg::ADJ_W-1:0]      adj_s_z,
  output logic signed [jam_pkg::ADJ_W-1:0]      adj_t_z,
  output logic signed [jam_pkg::DET_W-1:0]      running_min,
  output logic signed [jam_pkg::DET_W-1:0]      running_max
);

  logic [jam_pkg::DIM_W-1:0] dimension;
  logic                      cfg_write;
  logic                      planar;
  jam_pkg::jam_cmd_t         cmd;

  // register access: one register, selected when paddr[2] is zero, zero-wait transfers
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= jam_pkg::DIM_RESET;
    end else if (cfg_write && paddr[2] == jam_pkg::REG_DIM) begin
      dimension <= pwdata[jam_pkg::DIM_W-1:0];
    end
  end

  assign prdata = (paddr[2] == jam_pkg::REG_DIM) ?
                  {{(jam_pkg::DATA_W - jam_pkg::DIM_W){1'b0}}, dimension} : '0;

  // dimension two picks planar terms, every other code runs the full 3x3 set
  assign planar = (dimension == jam_pkg::DIM_PLANAR);

  // sequencer: one point in flight, result held until the sink takes it
  jam_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pt_valid  (pt_valid),
    .pt_stall  (pt_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .planar    (planar),
    .cmd       (cmd)
  );

  // datapath: shared multiplier, adjugate and determinant accumulation, min/max
  jam_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .dx_dr       (dx_dr),
    .dy_dr       (dy_dr),
    .dz_dr       (dz_dr),
    .dx_ds       (dx_ds),
    .dy_ds       (dy_ds),
    .dz_ds       (dz_ds),
    .dx_dt       (dx_dt),
    .dy_dt       (dy_dt),
    .dz_dt       (dz_dt),
    .first_point (first_point),
    .is_padding  (is_padding),
    .determinant (determinant),
    .adj_r_x     (adj_r_x),
    .adj_s_x     (adj_s_x),
    .adj_t_x     (adj_t_x),
    .adj_r_y     (adj_r_y),
    .adj_s_y     (adj_s_y),
    .adj_t_y     (adj_t_y),
    .adj_r_z     (adj_r_z),
    .adj_s_z     (adj_s_z),
    .adj_t_z     (adj_t_z),
    .running_min (running_min),
    .running_max (running_max)
  );

  // a point transfer always starts a busy period
  `CHK_NEXT(a_busy_after_point, clk, rst, pt_valid && !pt_stall, pt_stall, "not busy after point")
  // a result only appears at the end of a busy period
  `CHK_IMPLIES(a_result_after_work, clk, rst, $rose(res_valid), $past(pt_stall), "result without work")
  // the running minimum never passes the running maximum
  `CHK_IMPLIES(a_min_le_max, clk, rst, res_valid, running_min <= running_max, "min above max")

endmodule

>>> tb/sv/jacobian_adjugate_minmax_top_tb.sv
// self-checking testbench for the jacobian determinant, adjugate and min/max block
module jacobian_adjugate_minmax_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC        = 16;
  localparam int ONE         = 1 << FRAC;
  localparam int COORD_MAX   = 8388607;
  localparam int COORD_MIN   = -8388608;
  localparam int RAND_PHASES = 16;
  localparam int PHASE_ITEMS = 78;
  localparam int ELEM_MAX    = 8;
  // a little more than the 3-d latency of the block
  localparam int SETTLE_CYCLES = 30;

  // saturation bounds widened for the predictor
  localparam longint DET_LO_BOUND = longint'(jam_pkg::DET_MIN);
  localparam longint DET_HI_BOUND = longint'(jam_pkg::DET_MAX);
  localparam longint ADJ_LO_BOUND = longint'(jam_pkg::ADJ_MIN);
  localparam longint ADJ_HI_BOUND = longint'(jam_pkg::ADJ_MAX);

  // dimension codes beside the planar one; every value but planar means 3-d
  localparam logic [jam_pkg::DIM_W-1:0] DIM_SPATIAL = 2'd3;
  localparam logic [jam_pkg::DIM_W-1:0] DIM_ALT_0   = 2'd0;
  localparam logic [jam_pkg::DIM_W-1:0] DIM_ALT_1   = 2'd1;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  // one integration point as it crosses the point channel
  typedef struct packed {
    logic signed [jam_pkg::IN_W-1:0] xr, yr, zr, xs, ys, zs, xt, yt, zt;
    logic                            first;
    logic                            pad;
  } point_t;

  // one result: determinant, nine adjugate terms, running min and max
  typedef struct packed {
    logic signed [jam_pkg::DET_W-1:0] det;
    logic signed [jam_pkg::ADJ_W-1:0] rx, sx, tx, ry, sy, ty, rz, sz, tz;
    logic signed [jam_pkg::DET_W-1:0] lo, hi;
  } metric_t;

  // predicts the metric terms of each accepted point and checks the results in order
  class metric_tracker;
    logic [jam_pkg::DIM_W-1:0] dim_cfg;
    longint                    det_lo;
    longint                    det_hi;
    metric_t                   pending_metrics[$];
    int                        mismatches;

    function new();
      dim_cfg    = jam_pkg::DIM_RESET;
      det_lo     = 0;
      det_hi     = 0;
      mismatches = 0;
    endfunction

    function void set_dimension(logic [jam_pkg::DIM_W-1:0] d);
      dim_cfg = d;
    endfunction

    function int pending();
      return pending_metrics.size();
    endfunction

    // exact difference of two products, floored back to the fraction width
    function longint cross_q(longint a, longint b, longint c, longint d);
      return (a * b - c * d) >>> FRAC;
    endfunction

    function longint sat(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function logic signed [jam_pkg::ADJ_W-1:0] sat_adj(longint v);
      return jam_pkg::ADJ_W'(sat(v, ADJ_LO_BOUND, ADJ_HI_BOUND));
    endfunction

    function void note_mismatch(string what, longint want, longint got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch %s: expected %0d actual %0d", $realtime, what, want, got);
    endfunction

    function void note_point(point_t p);
      longint  xr, yr, zr, xs, ys, zs, xt, yt, zt;
      longint  adj[9];
      longint  det;
      metric_t m;
      xr = longint'(p.xr); yr = longint'(p.yr); zr = longint'(p.zr);
      xs = longint'(p.xs); ys = longint'(p.ys); zs = longint'(p.zs);
      xt = longint'(p.xt); yt = longint'(p.yt); zt = longint'(p.zt);
      if (dim_cfg == jam_pkg::DIM_PLANAR) begin
        det    = cross_q(xr, ys, xs, yr);
        adj[0] = ys;
        adj[1] = -yr;
        adj[2] = 0;
        adj[3] = -xs;
        adj[4] = xr;
        for (int k = 5; k < 9; k++) adj[k] = 0;
      end else begin
        adj[0] = cross_q(ys, zt, zs, yt);
        adj[1] = cross_q(zr, yt, yr, zt);
        adj[2] = cross_q(yr, zs, zr, ys);
        adj[3] = cross_q(zs, xt, xs, zt);
        adj[4] = cross_q(xr, zt, zr, xt);
        adj[5] = cross_q(zr, xs, xr, zs);
        adj[6] = cross_q(xs, yt, ys, xt);
        adj[7] = cross_q(yr, xt, xr, yt);
        adj[8] = cross_q(xr, ys, yr, xs);
        // determinant uses the floored, not yet saturated adjugate terms
        det = ((xr * adj[0]) >>> FRAC) + ((xs * adj[1]) >>> FRAC) + ((xt * adj[2]) >>> FRAC);
      end
      det = sat(det, DET_LO_BOUND, DET_HI_BOUND);
      if (!p.pad) begin
        if (p.first) begin
          det_lo = det;
          det_hi = det;
        end else begin
          if (det < det_lo) det_lo = det;
          if (det > det_hi) det_hi = det;
        end
      end
      m.det = det[jam_pkg::DET_W-1:0];
      m.rx  = sat_adj(adj[0]);
      m.sx  = sat_adj(adj[1]);
      m.tx  = sat_adj(adj[2]);
      m.ry  = sat_adj(adj[3]);
      m.sy  = sat_adj(adj[4]);
      m.ty  = sat_adj(adj[5]);
      m.rz  = sat_adj(adj[6]);
      m.sz  = sat_adj(adj[7]);
      m.tz  = sat_adj(adj[8]);
      m.lo  = det_lo[jam_pkg::DET_W-1:0];
      m.hi  = det_hi[jam_pkg::DET_W-1:0];
      pending_metrics.push_back(m);
    endfunction

    function void check_metrics(metric_t got);
      metric_t want;
      if (pending_metrics.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t result transfer with nothing expected, determinant %0d",
                   $realtime, got.det);
        return;
      end
      want = pending_metrics.pop_front();
      if (got.det !== want.det)
        note_mismatch("determinant", longint'(want.det), longint'(got.det));
      if (got.rx !== want.rx) note_mismatch("adj_r_x", longint'(want.rx), longint'(got.rx));
      if (got.sx !== want.sx) note_mismatch("adj_s_x", longint'(want.sx), longint'(got.sx));
      if (got.tx !== want.tx) note_mismatch("adj_t_x", longint'(want.tx), longint'(got.tx));
      if (got.ry !== want.ry) note_mismatch("adj_r_y", longint'(want.ry), longint'(got.ry));
      if (got.sy !== want.sy) note_mismatch("adj_s_y", longint'(want.sy), longint'(got.sy));
      if (got.ty !== want.ty) note_mismatch("adj_t_y", longint'(want.ty), longint'(got.ty));
      if (got.rz !== want.rz) note_mismatch("adj_r_z", longint'(want.rz), longint'(got.rz));
      if (got.sz !== want.sz) note_mismatch("adj_s_z", longint'(want.sz), longint'(got.sz));
      if (got.tz !== want.tz) note_mismatch("adj_t_z", longint'(want.tz), longint'(got.tz));
      if (got.lo !== want.lo)
        note_mismatch("running_min", longint'(want.lo), longint'(got.lo));
      if (got.hi !== want.hi)
        note_mismatch("running_max", longint'(want.hi), longint'(got.hi));
    endfunction
  endclass

  logic                              clk;
  logic                              rst;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [jam_pkg::ADDR_W-1:0]        paddr;
  logic [jam_pkg::DATA_W-1:0]        pwdata;
  logic [jam_pkg::DATA_W-1:0]        prdata;
  logic                              pready;
  logic                              pt_valid;
  logic                              pt_stall;
  logic signed [jam_pkg::IN_W-1:0]   dx_dr, dy_dr, dz_dr, dx_ds, dy_ds, dz_ds;
  logic signed [jam_pkg::IN_W-1:0]   dx_dt, dy_dt, dz_dt;
  logic                              first_point;
  logic                              is_padding;
  logic                              res_valid;
  logic                              res_stall;
  logic signed [jam_pkg::DET_W-1:0]  determinant;
  logic signed [jam_pkg::ADJ_W-1:0]  adj_r_x, adj_s_x, adj_t_x, adj_r_y, adj_s_y, adj_t_y;
  logic signed [jam_pkg::ADJ_W-1:0]  adj_r_z, adj_s_z, adj_t_z;
  logic signed [jam_pkg::DET_W-1:0]  running_min;
  logic signed [jam_pkg::DET_W-1:0]  running_max;

  metric_tracker board = new();
  idle_mode_t    idle_mode = IDLE_NONE;

  jacobian_adjugate_minmax_top #(
    .FRAC_BITS(FRAC)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .pt_valid   (pt_valid),
    .pt_stall   (pt_stall),
    .dx_dr      (dx_dr),
    .dy_dr      (dy_dr),
    .dz_dr      (dz_dr),
    .dx_ds      (dx_ds),
    .dy_ds      (dy_ds),
    .dz_ds      (dz_ds),
    .dx_dt      (dx_dt),
    .dy_dt      (dy_dt),
    .dz_dt      (dz_dt),
    .first_point(first_point),
    .is_padding (is_padding),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .determinant(determinant),
    .adj_r_x    (adj_r_x),
    .adj_s_x    (adj_s_x),
    .adj_t_x    (adj_t_x),
    .adj_r_y    (adj_r_y),
    .adj_s_y    (adj_s_y),
    .adj_t_y    (adj_t_y),
    .adj_r_z    (adj_r_z),
    .adj_s_z    (adj_s_z),
    .adj_t_z    (adj_t_z),
    .running_min(running_min),
    .running_max(running_max)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sender holds off with chance 88 in 100 when it idles alone, 37 in 100 when both sides idle
  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99) < 88;
      IDLE_BOTH: return $urandom_range(99) < 37;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(99) < 88;
      IDLE_BOTH: return $urandom_range(99) < 37;
      default:   return 1'b0;
    endcase
  endfunction

  // coordinate derivative: mostly moderate values, some full range, some extremes
  function automatic logic signed [jam_pkg::IN_W-1:0] rand_coord();
    case ($urandom_range(9))
      0: return jam_pkg::IN_W'($urandom);
      1: begin
        case ($urandom_range(6))
          0: return jam_pkg::IN_W'(COORD_MAX);
          1: return jam_pkg::IN_W'(COORD_MIN);
          2: return '0;
          3: return '1;
          4: return jam_pkg::IN_W'(1);
          5: return jam_pkg::IN_W'(ONE);
          default: return jam_pkg::IN_W'(-ONE);
        endcase
      end
      default: return jam_pkg::IN_W'(int'($urandom_range(8 * ONE)) - 4 * ONE);
    endcase
  endfunction

  function automatic point_t mk_point(int xr, int yr, int zr, int xs, int ys, int zs,
                                      int xt, int yt, int zt, bit first, bit pad);
    point_t p;
    p.xr = jam_pkg::IN_W'(xr); p.yr = jam_pkg::IN_W'(yr); p.zr = jam_pkg::IN_W'(zr);
    p.xs = jam_pkg::IN_W'(xs); p.ys = jam_pkg::IN_W'(ys); p.zs = jam_pkg::IN_W'(zs);
    p.xt = jam_pkg::IN_W'(xt); p.yt = jam_pkg::IN_W'(yt); p.zt = jam_pkg::IN_W'(zt);
    p.first = first;
    p.pad   = pad;
    return p;
  endfunction

  // one apb access: setup cycle, then access cycle until pready, then a cycle with psel low
  task automatic apb_access(input bit wr, input logic [jam_pkg::DATA_W-1:0] wdata,
                            output logic [jam_pkg::DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= jam_pkg::ADDR_W'(4 * int'(jam_pkg::REG_DIM));
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // write the dimension register with junk in the unused bits, then read it back
  task automatic set_dimension(input logic [jam_pkg::DIM_W-1:0] d);
    logic [jam_pkg::DATA_W-1:0] rd;
    apb_access(1'b1, ($urandom & ~jam_pkg::DATA_W'(3)) | jam_pkg::DATA_W'(d), rd);
    board.set_dimension(d);
    apb_access(1'b0, '0, rd);
    if (rd[jam_pkg::DIM_W-1:0] !== d)
      board.note_mismatch("dimension readback", longint'(d),
                          longint'(rd[jam_pkg::DIM_W-1:0]));
  endtask

  // one point transfer; payload only changes after the previous transfer
  task automatic send_point(input point_t p);
    while (sender_idles()) begin
      pt_valid <= 1'b0;
      @(posedge clk);
    end
    dx_dr       <= p.xr;
    dy_dr       <= p.yr;
    dz_dr       <= p.zr;
    dx_ds       <= p.xs;
    dy_ds       <= p.ys;
    dz_ds       <= p.zs;
    dx_dt       <= p.xt;
    dy_dt       <= p.yt;
    dz_dt       <= p.zt;
    first_point <= p.first;
    is_padding  <= p.pad;
    pt_valid    <= 1'b1;
    do @(posedge clk); while (pt_stall);
    board.note_point(p);
  endtask

  // hold the sender off until every expected result has come, then let the pipe settle
  task automatic drain_results();
    pt_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: check each transfer, then choose the stall for the next cycle
  initial begin
    metric_t got;
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) begin
        got = '{determinant, adj_r_x, adj_s_x, adj_t_x, adj_r_y, adj_s_y, adj_t_y,
                adj_r_z, adj_s_z, adj_t_z, running_min, running_max};
        board.check_metrics(got);
      end
      res_stall <= receiver_stalls();
    end
  end

  // stimulus
  initial begin
    point_t                     pt;
    logic [jam_pkg::DATA_W-1:0] rd;
    logic [jam_pkg::DIM_W-1:0]  dim_order[4];
    int                         left;
    int                         idx;
    int                         pad_from;
    bit                         noise;

    dim_order[0] = DIM_SPATIAL;
    dim_order[1] = jam_pkg::DIM_PLANAR;
    dim_order[2] = DIM_ALT_0;
    dim_order[3] = DIM_ALT_1;

    // every input known from time zero
    rst         <= 1'b1;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    pt_valid    <= 1'b0;
    dx_dr       <= '0;
    dy_dr       <= '0;
    dz_dr       <= '0;
    dx_ds       <= '0;
    dy_ds       <= '0;
    dz_ds       <= '0;
    dx_dt       <= '0;
    dy_dt       <= '0;
    dz_dt       <= '0;
    first_point <= 1'b0;
    is_padding  <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // dimension comes out of reset as 3-d
    apb_access(1'b0, '0, rd);
    if (rd[jam_pkg::DIM_W-1:0] !== jam_pkg::DIM_RESET)
      board.note_mismatch("dimension after reset", longint'(jam_pkg::DIM_RESET),
                          longint'(rd[jam_pkg::DIM_W-1:0]));

    // directed 3-d points, no idling
    set_dimension(DIM_SPATIAL);
    // identity restarts min and max
    send_point(mk_point(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 1'b1, 1'b0));
    send_point(mk_point(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                        COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b0));
    send_point(mk_point(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                        COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1'b0));
    send_point(mk_point(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    send_point(mk_point(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX,
                        COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, 1'b0, 1'b0));
    // largest positive and negative diagonal determinants
    send_point(mk_point(COORD_MAX, 0, 0, 0, COORD_MAX, 0, 0, 0, COORD_MAX, 1'b0, 1'b0));
    send_point(mk_point(COORD_MIN, 0, 0, 0, COORD_MIN, 0, 0, 0, COORD_MIN, 1'b0, 1'b0));
    // all minus one lsb: floors of negative products
    send_point(mk_point(-1, -1, -1, -1, -1, -1, -1, -1, -1, 1'b0, 1'b0));
    send_point(mk_point(1, 0, 0, 0, 1, 0, 0, 0, 1, 1'b0, 1'b0));
    // padding point with first set leaves min and max alone
    send_point(mk_point(COORD_MAX, 0, 0, 0, COORD_MAX, 0, 0, 0, COORD_MAX, 1'b1, 1'b1));
    // swapped rows give a negative determinant
    send_point(mk_point(0, ONE, 0, ONE, 0, 0, 0, 0, ONE, 1'b0, 1'b0));
    send_point(mk_point(3 * ONE / 2, ONE / 4, -ONE / 3, ONE / 5, 2 * ONE, ONE / 7,
                        -ONE / 9, ONE / 11, 5 * ONE / 2, 1'b1, 1'b0));
    send_point(mk_point(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                        COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 1'b0, 1'b0));

    // directed planar points; z and t fields carry junk that must be ignored
    drain_results();
    set_dimension(jam_pkg::DIM_PLANAR);
    send_point(mk_point(ONE, 0, COORD_MAX, 0, ONE, COORD_MIN, COORD_MAX, COORD_MIN,
                        COORD_MAX, 1'b1, 1'b0));
    send_point(mk_point(COORD_MAX, COORD_MIN, 0, COORD_MIN, COORD_MAX, 0, 0, 0, 0,
                        1'b0, 1'b0));
    send_point(mk_point(COORD_MAX, COORD_MAX, 0, COORD_MAX, COORD_MIN, 0, 0, 0, 0,
                        1'b0, 1'b0));
    send_point(mk_point(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                        COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1'b0));
    send_point(mk_point(-1, -1, -1, -1, -1, -1, -1, -1, -1, 1'b0, 1'b0));
    send_point(mk_point(COORD_MIN, 0, 0, 0, COORD_MAX, 0, 0, 0, 0, 1'b1, 1'b1));
    send_point(mk_point(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));

    // random phases: every dimension code under every idle mode
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_results();
      idle_mode = idle_mode_t'((p + p / 4) % 4);
      set_dimension(dim_order[p % 4]);
      left = 0;
      idx  = 0;
      pad_from = 0;
      noise = 1'b0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // sender waits for the pipe to empty in the middle of one phase
        if (p == 6 && k == PHASE_ITEMS / 2) drain_results();
        // elements: first point flagged, optional padding tail, some broken flag patterns
        if (left == 0) begin
          left     = int'($urandom_range(1, ELEM_MAX));
          pad_from = ($urandom_range(3) == 0) ? int'($urandom_range(1, left)) : left;
          noise    = $urandom_range(99) < 15;
          idx      = 0;
        end
        pt.xr = rand_coord(); pt.yr = rand_coord(); pt.zr = rand_coord();
        pt.xs = rand_coord(); pt.ys = rand_coord(); pt.zs = rand_coord();
        pt.xt = rand_coord(); pt.yt = rand_coord(); pt.zt = rand_coord();
        if (noise) begin
          pt.first = 1'($urandom_range(1));
          pt.pad   = 1'($urandom_range(1));
        end else begin
          pt.first = (idx == 0);
          pt.pad   = (idx >= pad_from);
        end
        idx++;
        left--;
        send_point(pt);
      end
    end

    // all points transferred: wait for the last results and a quiet tail
    idle_mode = IDLE_NONE;
    drain_results();
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("jacobian_adjugate_minmax_top_tb passed");
    end else begin
      $display("jacobian_adjugate_minmax_top_tb failed");
    end
    $finish;
  end

  // run limit, many times the slowest correct run
  initial begin
    #12_000_000;
    $display("jacobian_adjugate_minmax_top_tb failed");
    $finish;
  end

endmodule
